[hdl/tun_pkg.sv]
`default_nettype none

package tun_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 14;
  localparam int FieldBits = 16;

  localparam int EdgeBits = CoordBits + 1;
  localparam int MagBits  = 2 * CoordBits + 1;
  localparam int HiBits   = MagBits - EdgeBits;
  localparam int SqBits   = 2 * MagBits;
  localparam int SumBits  = SqBits + 2;
  localparam int DiffBits = SumBits + 2 * FracBits + 6;
  localparam int PBits    = SumBits + FracBits + 3;
  localparam int QBits    = FracBits + 1;

  localparam int SrchStages = QBits;
  localparam int OutMax     = 2 ** (FieldBits - 1) - 1;
  localparam int OutMin     = -(2 ** (FieldBits - 1));

  typedef struct packed {
    logic signed [FieldBits-1:0] ax;
    logic signed [FieldBits-1:0] ay;
    logic signed [FieldBits-1:0] az;
    logic signed [FieldBits-1:0] bx;
    logic signed [FieldBits-1:0] by_coord;
    logic signed [FieldBits-1:0] bz;
    logic signed [FieldBits-1:0] cx;
    logic signed [FieldBits-1:0] cy;
    logic signed [FieldBits-1:0] cz;
  } tri_t;

  typedef struct packed {
    logic signed [FieldBits-1:0] normal_x;
    logic signed [FieldBits-1:0] normal_y;
    logic signed [FieldBits-1:0] normal_z;
    logic                        degenerate;
  } normal_t;

  typedef struct packed {
    logic               neg;
    logic [MagBits-1:0] mag;
  } comp_mag_t;

  typedef struct packed {
    logic            degen;
    comp_mag_t [2:0] c;
  } cross_t;

  typedef struct packed {
    logic                       neg;
    logic signed [DiffBits-1:0] r;
    logic signed [PBits-1:0]    p;
    logic [QBits-1:0]           q;
  } srch_comp_t;

  typedef struct packed {
    logic               degen;
    logic [SumBits-1:0] s;
    srch_comp_t [2:0]   c;
  } srch_t;

endpackage

`default_nettype wire

[hdl/tun_cross.sv]
`default_nettype none

module tun_cross (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire tun_pkg::tri_t   tri_i,
  output logic                 valid_o,
  output tun_pkg::cross_t      cross_o
);

  localparam int EW = tun_pkg::EdgeBits;
  localparam int PW = 2 * tun_pkg::EdgeBits;

  function automatic logic signed [EW-1:0] sx(input logic [tun_pkg::FieldBits-1:0] f);
    logic [tun_pkg::CoordBits+tun_pkg::FieldBits-1:0] z;
    z = {{tun_pkg::CoordBits{1'b0}}, f};
    return EW'(signed'(z[tun_pkg::CoordBits-1:0]));
  endfunction

  logic [2:0]              vld_q;
  logic signed [EW-1:0]    edge_d [6];
  logic signed [EW-1:0]    edge_q [6];
  logic signed [PW-1:0]    prod_d [6];
  logic signed [PW-1:0]    prod_q [6];
  tun_pkg::cross_t         cross_d;
  tun_pkg::cross_t         cross_q;
  logic signed [PW-1:0]    n [3];
  logic signed [PW-1:0]    m [3];

  // stage 1: edge vectors
  always_comb begin
    edge_d[0] = sx(tri_i.bx) - sx(tri_i.ax);
    edge_d[1] = sx(tri_i.by_coord) - sx(tri_i.ay);
    edge_d[2] = sx(tri_i.bz) - sx(tri_i.az);
    edge_d[3] = sx(tri_i.cx) - sx(tri_i.ax);
    edge_d[4] = sx(tri_i.cy) - sx(tri_i.ay);
    edge_d[5] = sx(tri_i.cz) - sx(tri_i.az);
  end

  // stage 2: the six cross-product terms
  always_comb begin
    prod_d[0] = PW'(edge_q[1]) * PW'(edge_q[5]);
    prod_d[1] = PW'(edge_q[2]) * PW'(edge_q[4]);
    prod_d[2] = PW'(edge_q[2]) * PW'(edge_q[3]);
    prod_d[3] = PW'(edge_q[0]) * PW'(edge_q[5]);
    prod_d[4] = PW'(edge_q[0]) * PW'(edge_q[4]);
    prod_d[5] = PW'(edge_q[1]) * PW'(edge_q[3]);
  end

  // stage 3: differences, sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i] = prod_q[2*i] - prod_q[2*i+1];
      m[i] = n[i][PW-1] ? -n[i] : n[i];
      cross_d.c[i].neg = n[i][PW-1];
      cross_d.c[i].mag = m[i][tun_pkg::MagBits-1:0];
    end
    cross_d.degen = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q  <= edge_d;
    prod_q  <= prod_d;
    cross_q <= cross_d;
  end

  assign valid_o = vld_q[2];
  assign cross_o = cross_q;

endmodule

`default_nettype wire

[hdl/tun_setup.sv]
`default_nettype none

module tun_setup (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire tun_pkg::cross_t cross_i,
  output logic                 valid_o,
  output tun_pkg::srch_t       srch_o
);

  localparam int EW = tun_pkg::EdgeBits;
  localparam int HW = tun_pkg::HiBits;
  localparam int QW = tun_pkg::SqBits;
  localparam int DW = tun_pkg::DiffBits;
  localparam int PW = tun_pkg::PBits;
  localparam int SW = tun_pkg::SumBits;

  logic [3:0]            vld_q;
  logic [2:0]            neg1_q, neg2_q, neg3_q;
  logic                  degen1_q, degen2_q, degen3_q;
  logic [2*HW-1:0]       hh_d [3];
  logic [2*HW-1:0]       hh_q [3];
  logic [HW+EW-1:0]      hl_d [3];
  logic [HW+EW-1:0]      hl_q [3];
  logic [2*EW-1:0]       ll_d [3];
  logic [2*EW-1:0]       ll_q [3];
  logic [QW-1:0]         sq_d [3];
  logic [QW-1:0]         sq_q [3];
  logic [DW-1:0]         t_d [3];
  logic [DW-1:0]         t_q [3];
  logic [SW-1:0]         s_d, s_q;
  tun_pkg::srch_t        srch_d, srch_q;

  // stage 1: square split into halves so each multiplier stays narrow
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hh_d[i] = (2*HW)'(cross_i.c[i].mag[tun_pkg::MagBits-1:EW])
              * (2*HW)'(cross_i.c[i].mag[tun_pkg::MagBits-1:EW]);
      hl_d[i] = (HW+EW)'(cross_i.c[i].mag[tun_pkg::MagBits-1:EW])
              * (HW+EW)'(cross_i.c[i].mag[EW-1:0]);
      ll_d[i] = (2*EW)'(cross_i.c[i].mag[EW-1:0]) * (2*EW)'(cross_i.c[i].mag[EW-1:0]);
    end
  end

  // stage 2: recombine the squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = (QW'(hh_q[i]) << (2*EW)) + (QW'(hl_q[i]) << (EW+1)) + QW'(ll_q[i]);
    end
  end

  // stage 3: squared length and the per-component target c^2 * 4^(F+1)
  always_comb begin
    s_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    for (int i = 0; i < 3; i++) begin
      t_d[i] = DW'(sq_q[i]) << (2*tun_pkg::FracBits + 2);
    end
  end

  // stage 4: search starts at q = 0, i.e. (2q-1)^2 * S = S
  always_comb begin
    srch_d.degen = degen3_q;
    srch_d.s     = s_q;
    for (int i = 0; i < 3; i++) begin
      srch_d.c[i].neg = neg3_q[i];
      srch_d.c[i].r   = signed'(t_q[i]) - signed'(DW'(s_q));
      srch_d.c[i].p   = -signed'(PW'(s_q));
      srch_d.c[i].q   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    hh_q     <= hh_d;
    hl_q     <= hl_d;
    ll_q     <= ll_d;
    neg1_q   <= {cross_i.c[2].neg, cross_i.c[1].neg, cross_i.c[0].neg};
    degen1_q <= cross_i.degen;
    sq_q     <= sq_d;
    neg2_q   <= neg1_q;
    degen2_q <= degen1_q;
    t_q      <= t_d;
    s_q      <= s_d;
    neg3_q   <= neg2_q;
    degen3_q <= degen2_q;
    srch_q   <= srch_d;
  end

  assign valid_o = vld_q[3];
  assign srch_o  = srch_q;

endmodule

`default_nettype wire

[hdl/tun_search.sv]
`default_nettype none

module tun_search (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire tun_pkg::srch_t srch_i,
  output logic                valid_o,
  output tun_pkg::srch_t      srch_o
);

  localparam int NS = tun_pkg::SrchStages;
  localparam int DW = tun_pkg::DiffBits;
  localparam int PW = tun_pkg::PBits;

  logic           vin [NS];
  logic           vld_q [NS];
  tun_pkg::srch_t stg_in [NS];
  tun_pkg::srch_t stg_q [NS];

  assign vin[0]    = valid_i;
  assign stg_in[0] = srch_i;

  // One quotient bit per stage, MSB first. r holds target - (2q-1)^2*S and
  // p holds (2q-1)*S, so raising q by 2^k needs only shifted adds.
  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam int K = tun_pkg::QBits - 1 - g;

    logic signed [DW-1:0] trial [3];
    tun_pkg::srch_t       nxt;

    if (g > 0) begin : g_link
      assign vin[g]    = vld_q[g-1];
      assign stg_in[g] = stg_q[g-1];
    end

    always_comb begin
      nxt = stg_in[g];
      for (int i = 0; i < 3; i++) begin
        trial[i] = stg_in[g].c[i].r
                 - (DW'(stg_in[g].c[i].p) <<< (K + 2))
                 - signed'(DW'(stg_in[g].s) << (2*K + 2));
        if (!trial[i][DW-1]) begin
          nxt.c[i].r    = trial[i];
          nxt.c[i].p    = stg_in[g].c[i].p + signed'(PW'(stg_in[g].s) << (K + 1));
          nxt.c[i].q[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vin[g];
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[g] <= nxt;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign srch_o  = stg_q[NS-1];

endmodule

`default_nettype wire

[hdl/triangle_unit_normal_top.sv]
`default_nettype none

// Unit face normal of a triangle, Q1.14, rounded to nearest (halves away
// from zero). A triangle is taken on every cycle that start is high; busy
// stays low, so the block takes one triangle per clock. Each triangle gives
// one result beat on done_o, after the edge and cross-product stages, the
// squaring and setup stages, the rounding search over the FracBits + 1 = 15
// result bits, and an output register.
// A zero cross product returns a zero normal with degenerate set.
// done_o is a one-cycle strobe that the receiver must take.
module triangle_unit_normal_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire tun_pkg::tri_t    tri_i,
  output logic                  done_o,
  output tun_pkg::normal_t      result_o
);

  localparam int QW   = tun_pkg::QBits;
  localparam int FW   = tun_pkg::FieldBits;
  localparam int Unit = 2 ** tun_pkg::FracBits;

  logic             cross_vld;
  tun_pkg::cross_t  xprod;
  logic             setup_vld;
  tun_pkg::srch_t   setup;
  logic             srch_vld;
  tun_pkg::srch_t   srch;
  logic             done_q;
  tun_pkg::normal_t result_d, result_q;

  function automatic logic signed [FW-1:0] to_field(input logic neg,
                                                    input logic [QW-1:0] q);
    logic signed [QW+FW+1:0] v;
    v = signed'({{(FW+2){1'b0}}, q});
    if (neg) v = -v;
    if (v > tun_pkg::OutMax) begin
      return FW'(tun_pkg::OutMax);
    end else if (v < tun_pkg::OutMin) begin
      return FW'(tun_pkg::OutMin);
    end
    return v[FW-1:0];
  endfunction

  assign busy = 1'b0;

  tun_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .tri_i   (tri_i),
    .valid_o (cross_vld),
    .cross_o (xprod)
  );

  tun_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cross_vld),
    .cross_i (xprod),
    .valid_o (setup_vld),
    .srch_o  (setup)
  );

  tun_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (setup_vld),
    .srch_i  (setup),
    .valid_o (srch_vld),
    .srch_o  (srch)
  );

  always_comb begin
    if (srch.degen) begin
      result_d = '0;
      result_d.degenerate = 1'b1;
    end else begin
      result_d.normal_x   = to_field(srch.c[0].neg, srch.c[0].q);
      result_d.normal_y   = to_field(srch.c[1].neg, srch.c[1].q);
      result_d.normal_z   = to_field(srch.c[2].neg, srch.c[2].q);
      result_d.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= srch_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.degenerate |->
      result_o.normal_x == 0 && result_o.normal_y == 0 && result_o.normal_z == 0)
    else $error("degenerate beat carries a nonzero normal");

  a_degen_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_vld && srch.degen |=> done_o && result_o.degenerate)
    else $error("degenerate flag lost at the output stage");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.degenerate |->
      result_o.normal_x != 0 || result_o.normal_y != 0 || result_o.normal_z != 0)
    else $error("nondegenerate triangle gave a zero normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.degenerate |->
      (tun_pkg::FracBits >= FW - 1) ||
      (result_o.normal_x <= Unit && result_o.normal_x >= -Unit &&
       result_o.normal_y <= Unit && result_o.normal_y >= -Unit &&
       result_o.normal_z <= Unit && result_o.normal_z >= -Unit))
    else $error("normal component above unit length");

endmodule

`default_nettype wire
